// ===== rtl/scbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Size class buffer pool package
// Shared constants, request and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package scbp_pkg;

  // Default configuration of the pool array.
  localparam int NUM_POOLS_DEF     = 8;
  localparam int BUFS_PER_POOL_DEF = 64;
  localparam int GRANULE_BYTES_DEF = 64;

  // Fixed field widths of the ports.
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int GRAN_W    = 10;
  localparam int ACTION_W  = 2;
  localparam int SIZE_W    = 16;
  localparam int BPOOL_W   = 4;
  localparam int BSLOT_W   = 6;
  localparam int STATUS_W  = 3;
  localparam int GPOOL_W   = 3;
  localparam int GSLOT_W   = 6;
  localparam int COUNT_W   = 7;

  // Reset value of each size class register, in granules.
  localparam logic [GRAN_W-1:0] GRAN_RESET [NUM_REGS] = '{
    10'd1, 10'd2, 10'd4, 10'd8, 10'd16, 10'd32, 10'd64, 10'd128
  };

  // Request codes.
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep;   // initialise one memory entry
    logic load;    // capture a request and read the memories
    logic commit;  // update state and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // the sweep is on its final entry
  } sts_t;

endpackage

// ===== rtl/scbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Size class buffer pool controller
// Sequences the initialisation sweep, request capture and execution, and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module scbp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output scbp_pkg::cmd_t   cmd_o,
  input  scbp_pkg::sts_t   sts_i
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Commands: a request executes once the result register is free.
  always_comb begin
    cmd_o.sweep  = (state_q == S_SWEEP);
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // State and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_SWEEP: begin
          if (sts_i.sweep_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_o.commit) state_q <= S_IDLE;
        end
        default: state_q <= S_SWEEP;
      endcase

      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/scbp_dpath.sv =====
// ----------------------------------------------------------------------------
// Size class buffer pool datapath
// Size class registers, free slot rings and used marks in memory, per pool
// head, tail and free counters, and the result register.
// ----------------------------------------------------------------------------
module scbp_dpath #(
  parameter int NUM_POOLS     = scbp_pkg::NUM_POOLS_DEF,
  parameter int BUFS_PER_POOL = scbp_pkg::BUFS_PER_POOL_DEF,
  parameter int GRANULE_BYTES = scbp_pkg::GRANULE_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scbp_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scbp_pkg::GRAN_W-1:0]      cfg_data_i,
  input  logic [scbp_pkg::ACTION_W-1:0]    action_i,
  input  logic [scbp_pkg::SIZE_W-1:0]      req_size_i,
  input  logic [scbp_pkg::BPOOL_W-1:0]     buf_pool_i,
  input  logic [scbp_pkg::BSLOT_W-1:0]     buf_slot_i,
  input  scbp_pkg::cmd_t                   cmd_i,
  output scbp_pkg::sts_t                   sts_o,
  output logic [scbp_pkg::STATUS_W-1:0]    status_o,
  output logic [scbp_pkg::GPOOL_W-1:0]     got_pool_o,
  output logic [scbp_pkg::GSLOT_W-1:0]     got_slot_o,
  output logic [scbp_pkg::COUNT_W-1:0]     total_count_o,
  output logic [scbp_pkg::COUNT_W-1:0]     free_count_o
);

  localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int SLOT_W = $clog2(BUFS_PER_POOL);
  localparam int ADDR_W = POOL_W + SLOT_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = $clog2(BUFS_PER_POOL + 1);
  localparam int CAP_W  = scbp_pkg::GRAN_W + $clog2(GRANULE_BYTES + 1);

  // Size class capacity in bytes, and per pool ring pointers and counts.
  logic [CAP_W-1:0]  cap_q  [NUM_POOLS];
  logic [SLOT_W-1:0] head_q [NUM_POOLS];
  logic [SLOT_W-1:0] tail_q [NUM_POOLS];
  logic [CNT_W-1:0]  free_q [NUM_POOLS];

  // Memories.
  logic [SLOT_W-1:0] ring_mem [DEPTH];
  logic              used_mem [DEPTH];
  logic [ADDR_W-1:0] sweep_cnt_q;

  // Captured request.
  logic [scbp_pkg::ACTION_W-1:0] act_q;
  logic [POOL_W-1:0]             pool_q;
  logic [SLOT_W-1:0]             slot_q;
  logic [SLOT_W-1:0]             head_sel_q;
  logic                          size_bad_q;
  logic                          handle_ok_q;
  logic [SLOT_W-1:0]             ring_rd_q;
  logic                          used_rd_q;

  // Result register.
  logic [scbp_pkg::STATUS_W-1:0] status_q;
  logic [scbp_pkg::GPOOL_W-1:0]  got_pool_q;
  logic [scbp_pkg::GSLOT_W-1:0]  got_slot_q;
  logic [scbp_pkg::COUNT_W-1:0]  total_q;
  logic [scbp_pkg::COUNT_W-1:0]  free_cnt_q;

  // Request side signals.
  logic              sel_found;
  logic [POOL_W-1:0] sel_pool;
  logic [POOL_W-1:0] bp_trunc;
  logic [SLOT_W-1:0] bs_trunc;
  logic              handle_ok;
  logic [ADDR_W-1:0] ring_raddr;
  logic [ADDR_W-1:0] used_raddr;

  // Execute side signals.
  logic [CNT_W-1:0]              fc;
  logic                          do_alloc;
  logic                          do_free;
  logic [scbp_pkg::STATUS_W-1:0] res_status;
  logic [scbp_pkg::GPOOL_W-1:0]  res_pool;
  logic [scbp_pkg::GSLOT_W-1:0]  res_slot;
  logic [scbp_pkg::COUNT_W-1:0]  res_total;
  logic [scbp_pkg::COUNT_W-1:0]  res_free;
  logic [SLOT_W-1:0]             head_inc;
  logic [SLOT_W-1:0]             tail_inc;

  assign sts_o.sweep_last = &sweep_cnt_q;

  // Pick the first pool whose capacity covers the request.
  always_comb begin
    sel_found = 1'b0;
    sel_pool  = '0;
    for (int p = NUM_POOLS - 1; p >= 0; p--) begin
      if (32'(req_size_i) <= 32'(cap_q[p])) begin
        sel_found = 1'b1;
        sel_pool  = POOL_W'(p);
      end
    end
  end

  // Handle check and memory read addresses.
  assign bp_trunc   = POOL_W'(buf_pool_i);
  assign bs_trunc   = SLOT_W'(buf_slot_i);
  assign handle_ok  = (32'(buf_pool_i) < NUM_POOLS) && (32'(buf_slot_i) < BUFS_PER_POOL);
  assign ring_raddr = {sel_pool, head_q[sel_pool]};
  assign used_raddr = {bp_trunc, bs_trunc};

  // Capture the request when it is transferred in.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q       <= action_i;
      pool_q      <= (action_i == scbp_pkg::ACT_FREE) ? bp_trunc : sel_pool;
      slot_q      <= bs_trunc;
      head_sel_q  <= head_q[sel_pool];
      size_bad_q  <= (req_size_i == '0) || !sel_found;
      handle_ok_q <= handle_ok;
    end
  end

  // Execute the request against the captured reads.
  assign fc = free_q[pool_q];

  always_comb begin
    do_alloc   = 1'b0;
    do_free    = 1'b0;
    res_status = scbp_pkg::ST_OK;
    res_pool   = '0;
    res_slot   = '0;
    res_total  = '0;
    res_free   = '0;
    case (act_q)
      scbp_pkg::ACT_ALLOC: begin
        if (size_bad_q) begin
          res_status = scbp_pkg::ST_BAD_SIZE;
        end else if (fc == '0) begin
          res_status = scbp_pkg::ST_POOL_EMPTY;
          res_pool   = scbp_pkg::GPOOL_W'(pool_q);
        end else begin
          do_alloc = 1'b1;
          res_pool = scbp_pkg::GPOOL_W'(pool_q);
          res_slot = scbp_pkg::GSLOT_W'(ring_rd_q);
          res_free = scbp_pkg::COUNT_W'(fc - CNT_W'(1));
        end
      end
      scbp_pkg::ACT_FREE: begin
        if (!handle_ok_q) begin
          res_status = scbp_pkg::ST_BAD_HANDLE;
        end else if (!used_rd_q || (32'(fc) >= BUFS_PER_POOL)) begin
          res_status = scbp_pkg::ST_NOT_ALLOC;
          res_pool   = scbp_pkg::GPOOL_W'(pool_q);
          res_slot   = scbp_pkg::GSLOT_W'(slot_q);
          res_free   = scbp_pkg::COUNT_W'(fc);
        end else begin
          do_free  = 1'b1;
          res_pool = scbp_pkg::GPOOL_W'(pool_q);
          res_slot = scbp_pkg::GSLOT_W'(slot_q);
          res_free = scbp_pkg::COUNT_W'(fc + CNT_W'(1));
        end
      end
      scbp_pkg::ACT_QUERY: begin
        if (size_bad_q) begin
          res_status = scbp_pkg::ST_BAD_SIZE;
        end else begin
          res_pool  = scbp_pkg::GPOOL_W'(pool_q);
          res_total = scbp_pkg::COUNT_W'(BUFS_PER_POOL);
          res_free  = scbp_pkg::COUNT_W'(fc);
        end
      end
      default: begin
        res_status = scbp_pkg::ST_BAD_HANDLE;
      end
    endcase
  end

  // Ring pointer advance with wrap at the pool depth.
  assign head_inc = (32'(head_sel_q) == BUFS_PER_POOL - 1) ? '0 : head_sel_q + SLOT_W'(1);
  assign tail_inc = (32'(tail_q[pool_q]) == BUFS_PER_POOL - 1) ?
                    '0 : tail_q[pool_q] + SLOT_W'(1);

  // Size class registers, ring pointers and free counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        cap_q[p]  <= CAP_W'(32'(scbp_pkg::GRAN_RESET[p]) * GRANULE_BYTES);
        head_q[p] <= '0;
        tail_q[p] <= '0;
        free_q[p] <= CNT_W'(BUFS_PER_POOL);
      end
      sweep_cnt_q <= '0;
    end else begin
      if (cfg_we_i && (32'(cfg_idx_i) < NUM_POOLS)) begin
        cap_q[POOL_W'(cfg_idx_i)] <= CAP_W'(32'(cfg_data_i) * GRANULE_BYTES);
      end
      if (cmd_i.sweep) begin
        sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
      end
      if (cmd_i.commit && do_alloc) begin
        head_q[pool_q] <= head_inc;
        free_q[pool_q] <= fc - CNT_W'(1);
      end
      if (cmd_i.commit && do_free) begin
        tail_q[pool_q] <= tail_inc;
        free_q[pool_q] <= fc + CNT_W'(1);
      end
    end
  end

  // Free slot ring memory: initialised to slot numbers, pushed at the tail.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      ring_mem[sweep_cnt_q] <= sweep_cnt_q[SLOT_W-1:0];
    end else if (cmd_i.commit && do_free) begin
      ring_mem[{pool_q, tail_q[pool_q]}] <= slot_q;
    end
    if (cmd_i.load) begin
      ring_rd_q <= ring_mem[ring_raddr];
    end
  end

  // Used mark memory: cleared by the sweep, set on allocate, cleared on free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      used_mem[sweep_cnt_q] <= 1'b0;
    end else if (cmd_i.commit && do_alloc) begin
      used_mem[{pool_q, ring_rd_q}] <= 1'b1;
    end else if (cmd_i.commit && do_free) begin
      used_mem[{pool_q, slot_q}] <= 1'b0;
    end
    if (cmd_i.load) begin
      used_rd_q <= used_mem[used_raddr];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= res_status;
      got_pool_q <= res_pool;
      got_slot_q <= res_slot;
      total_q    <= res_total;
      free_cnt_q <= res_free;
    end
  end

  assign status_o      = status_q;
  assign got_pool_o    = got_pool_q;
  assign got_slot_o    = got_slot_q;
  assign total_count_o = total_q;
  assign free_count_o  = free_cnt_q;

endmodule

// ===== rtl/size_class_buffer_pool_unit.sv =====
// ----------------------------------------------------------------------------
// Size class buffer pool unit
// Fixed-block buffer allocator with configurable size classes: allocate,
// free and query requests against rings of free slot numbers per pool.
//
//   Channel   Direction  Handshake              Contents
//   in        input      in_valid_i/in_ready_o  action, req_size, buf_pool, buf_slot
//   out       output     out_valid_o/out_ready_i status, got_pool, got_slot, counts
//   cfg       input      cfg_we_i (no wait)      size class register index and data
//
// Each request is first captured, with a read of the ring and used mark
// memories, and is then executed, which updates them and loads the result register.
// The registered memory read must precede the write-back.
// After reset a sweep over all 2**(pool bits + slot bits) memory entries (512 by
// default) initialises the memories; no request is taken meanwhile, cfg writes are.
// A stalled result holds the next request in execution until it is taken.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_unit #(
  parameter int NUM_POOLS     = scbp_pkg::NUM_POOLS_DEF,
  parameter int BUFS_PER_POOL = scbp_pkg::BUFS_PER_POOL_DEF,
  parameter int GRANULE_BYTES = scbp_pkg::GRANULE_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scbp_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scbp_pkg::GRAN_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [scbp_pkg::ACTION_W-1:0]    action_i,
  input  logic [scbp_pkg::SIZE_W-1:0]      req_size_i,
  input  logic [scbp_pkg::BPOOL_W-1:0]     buf_pool_i,
  input  logic [scbp_pkg::BSLOT_W-1:0]     buf_slot_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [scbp_pkg::STATUS_W-1:0]    status_o,
  output logic [scbp_pkg::GPOOL_W-1:0]     got_pool_o,
  output logic [scbp_pkg::GSLOT_W-1:0]     got_slot_o,
  output logic [scbp_pkg::COUNT_W-1:0]     total_count_o,
  output logic [scbp_pkg::COUNT_W-1:0]     free_count_o
);

  scbp_pkg::cmd_t cmd;
  scbp_pkg::sts_t sts;

  // Sequencing and handshake.
  scbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Pools, memories and result register.
  scbp_dpath #(
    .NUM_POOLS     (NUM_POOLS),
    .BUFS_PER_POOL (BUFS_PER_POOL),
    .GRANULE_BYTES (GRANULE_BYTES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (action_i),
    .req_size_i    (req_size_i),
    .buf_pool_i    (buf_pool_i),
    .buf_slot_i    (buf_slot_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .got_pool_o    (got_pool_o),
    .got_slot_o    (got_slot_o),
    .total_count_o (total_count_o),
    .free_count_o  (free_count_o)
  );

endmodule

// ===== bench/scbp_checker.sv =====
// ----------------------------------------------------------------------------
// Size class buffer pool checker
// Watches the configuration port and both channels of the buffer pool unit.
// It keeps its own copy of the rings, used marks and counters, and works out
// the result of every request transfer. Each result transfer is then compared
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module scbp_checker
  import scbp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [GRAN_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [SIZE_W-1:0]    req_size_i,
  input  logic [BPOOL_W-1:0]   buf_pool_i,
  input  logic [BSLOT_W-1:0]   buf_slot_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [STATUS_W-1:0]  status_i,
  input  logic [GPOOL_W-1:0]   got_pool_i,
  input  logic [GSLOT_W-1:0]   got_slot_i,
  input  logic [COUNT_W-1:0]   total_count_i,
  input  logic [COUNT_W-1:0]   free_count_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOLS      = NUM_POOLS_DEF;
  localparam int BUFS       = BUFS_PER_POOL_DEF;
  localparam int GRAN_BYTES = GRANULE_BYTES_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GPOOL_W-1:0]  pool;
    logic [GSLOT_W-1:0]  slot;
    logic [COUNT_W-1:0]  total;
    logic [COUNT_W-1:0]  free_cnt;
  } pool_result_t;

  // Shadow state of the allocator.
  logic [GRAN_W-1:0]  class_gran [NUM_REGS];
  logic [GSLOT_W-1:0] free_slots [POOLS][BUFS];
  logic               slot_busy  [POOLS][BUFS];
  logic [GSLOT_W-1:0] rd_ptr     [POOLS];
  logic [GSLOT_W-1:0] wr_ptr     [POOLS];
  logic [COUNT_W-1:0] avail      [POOLS];

  pool_result_t expected_results [$];
  int mismatches = 0;
  int waiting    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  // Prints one line for a wrong or unexpected result and counts it.
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR %0t ns: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // First pool whose class holds the rounded-up size, or -1 for a zero or
  // oversize request.
  function automatic int pick_pool(input logic [SIZE_W-1:0] size);
    int need;
    if (size == '0) return -1;
    need = (int'(size) + GRAN_BYTES - 1) / GRAN_BYTES;
    for (int p = 0; p < POOLS; p++) begin
      if (int'(class_gran[p]) >= need) return p;
    end
    return -1;
  endfunction

  // Applies one request to the shadow state and returns its result.
  task automatic serve_request(input logic [ACTION_W-1:0] act,
                               input logic [SIZE_W-1:0] size,
                               input logic [BPOOL_W-1:0] bp,
                               input logic [BSLOT_W-1:0] bs,
                               output pool_result_t res);
    int p;
    logic [GSLOT_W-1:0] slot;
    res = '0;
    case (act)
      ACT_ALLOC: begin
        p = pick_pool(size);
        if (p < 0) begin
          res.status = ST_BAD_SIZE;
        end else if (avail[p] == '0) begin
          res.status = ST_POOL_EMPTY;
          res.pool   = GPOOL_W'(p);
        end else begin
          // Pop the head of the free ring.
          slot            = free_slots[p][rd_ptr[p]];
          rd_ptr[p]       = GSLOT_W'((int'(rd_ptr[p]) + 1) % BUFS);
          avail[p]        = avail[p] - 1'b1;
          slot_busy[p][slot] = 1'b1;
          res.status   = ST_OK;
          res.pool     = GPOOL_W'(p);
          res.slot     = slot;
          res.free_cnt = avail[p];
        end
      end
      ACT_FREE: begin
        if (int'(bp) >= POOLS || int'(bs) >= BUFS) begin
          res.status = ST_BAD_HANDLE;
        end else if (!slot_busy[bp][bs] || int'(avail[bp]) >= BUFS) begin
          res.status   = ST_NOT_ALLOC;
          res.pool     = bp[GPOOL_W-1:0];
          res.slot     = bs;
          res.free_cnt = avail[bp];
        end else begin
          // Push the slot back at the tail of its ring.
          slot_busy[bp][bs]          = 1'b0;
          free_slots[bp][wr_ptr[bp]] = bs;
          wr_ptr[bp]                 = GSLOT_W'((int'(wr_ptr[bp]) + 1) % BUFS);
          avail[bp]                  = avail[bp] + 1'b1;
          res.status   = ST_OK;
          res.pool     = bp[GPOOL_W-1:0];
          res.slot     = bs;
          res.free_cnt = avail[bp];
        end
      end
      ACT_QUERY: begin
        p = pick_pool(size);
        if (p < 0) begin
          res.status = ST_BAD_SIZE;
        end else begin
          res.status   = ST_OK;
          res.pool     = GPOOL_W'(p);
          res.total    = COUNT_W'(BUFS);
          res.free_cnt = avail[p];
        end
      end
      default: begin
        res.status = ST_BAD_HANDLE;
      end
    endcase
  endtask

  // Tracks configuration writes and both channels at every clock edge.
  always @(posedge clk_i or negedge rst_ni) begin : track
    pool_result_t got;
    pool_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) class_gran[i] = GRAN_RESET[i];
      for (int p = 0; p < POOLS; p++) begin
        for (int j = 0; j < BUFS; j++) begin
          free_slots[p][j] = GSLOT_W'(j);
          slot_busy[p][j]  = 1'b0;
        end
        rd_ptr[p] = '0;
        wr_ptr[p] = '0;
        avail[p]  = COUNT_W'(BUFS);
      end
      expected_results.delete();
    end else begin
      if (cfg_we_i && int'(cfg_idx_i) < NUM_REGS) begin
        class_gran[cfg_idx_i] = cfg_data_i;
      end
      // A result transfer is matched against the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        got = {status_i, got_pool_i, got_slot_i, total_count_i, free_count_i};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", 16'(got.status), 16'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 16'(got.status), 16'(want.status));
          if (got.pool !== want.pool)
            report_mismatch("got_pool", 16'(got.pool), 16'(want.pool));
          if (got.slot !== want.slot)
            report_mismatch("got_slot", 16'(got.slot), 16'(want.slot));
          if (got.total !== want.total)
            report_mismatch("total_count", 16'(got.total), 16'(want.total));
          if (got.free_cnt !== want.free_cnt)
            report_mismatch("free_count", 16'(got.free_cnt), 16'(want.free_cnt));
        end
      end
      // A request transfer produces exactly one prediction.
      if (in_valid_i && in_ready_i) begin
        serve_request(action_i, req_size_i, buf_pool_i, buf_slot_i, want);
        expected_results.push_back(want);
      end
    end
    waiting = expected_results.size();
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Size class buffer pool testbench
// Drives allocate, free and query requests into the buffer pool unit under
// several size class settings, with bursty request traffic and a stalling
// result receiver. The checker beside the block predicts and compares every
// result; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import scbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES   = 7;
  localparam int PHASE_ITEMS  = 265;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  // The one action code that the block does not define.
  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

  // Size class settings written between phases: all at 512 granules,
  // tiny classes, zero classes, unordered classes, and reset values.
  localparam logic [GRAN_W-1:0] CLASS_SETS [5][NUM_REGS] = '{
    '{10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512, 10'd512},
    '{10'd1,   10'd2,   10'd3,   10'd4,   10'd5,   10'd6,   10'd7,   10'd8},
    '{10'd0,   10'd0,   10'd3,   10'd0,   10'd10,  10'd64,  10'd200, 10'd512},
    '{10'd100, 10'd5,   10'd300, 10'd1,   10'd512, 10'd2,   10'd50,  10'd20},
    '{10'd1,   10'd2,   10'd4,   10'd8,   10'd16,  10'd32,  10'd64,  10'd128}
  };

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx    = '0;
  logic [GRAN_W-1:0]    cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  action     = '0;
  logic [SIZE_W-1:0]    req_size   = '0;
  logic [BPOOL_W-1:0]   buf_pool   = '0;
  logic [BSLOT_W-1:0]   buf_slot   = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [GPOOL_W-1:0]   got_pool;
  logic [GSLOT_W-1:0]   got_slot;
  logic [COUNT_W-1:0]   total_count;
  logic [COUNT_W-1:0]   free_count;
  int                   fail_count;
  int                   pending;

  // Stimulus side bookkeeping: current classes, handles that are out on
  // loan, and the actions of requests still in flight.
  logic [GRAN_W-1:0]   gran_cfg [NUM_REGS] = GRAN_RESET;
  logic [8:0]          held_buffers [$];
  logic [ACTION_W-1:0] inflight_actions [$];
  logic [ACTION_W-1:0] done_action;
  int                  burst_left   = 0;
  int                  stall_cycles = 0;
  logic                hold_go      = 1'b0;

  size_class_buffer_pool_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .req_size_i    (req_size),
    .buf_pool_i    (buf_pool),
    .buf_slot_i    (buf_slot),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .got_pool_o    (got_pool),
    .got_slot_o    (got_slot),
    .total_count_o (total_count),
    .free_count_o  (free_count)
  );

  scbp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .req_size_i    (req_size),
    .buf_pool_i    (buf_pool),
    .buf_slot_i    (buf_slot),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .got_pool_i    (got_pool),
    .got_slot_i    (got_slot),
    .total_count_i (total_count),
    .free_count_i  (free_count),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Collects handles of successful allocations so that frees can return them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready && inflight_actions.size() != 0) begin
        done_action = inflight_actions.pop_front();
        if (done_action == ACT_ALLOC && status == ST_OK)
          held_buffers.push_back({got_pool, got_slot});
      end
      if (in_valid && in_ready) inflight_actions.push_back(action);
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result receiver: segments of differing readiness, and one long hold-off
  // so that the block fills up and stalls its input.
  initial begin : receiver
    int seg_len;
    int ready_pct;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      seg_len = $urandom_range(200, 20);
      case ($urandom_range(4))
        0:       ready_pct = 100;
        1:       ready_pct = 90;
        2:       ready_pct = 60;
        3:       ready_pct = 30;
        default: ready_pct = 10;
      endcase
      repeat (seg_len) begin
        @(posedge clk_i);
        if (hold_go && !hold_done) begin
          hold_done = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        out_ready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  // Offers one request and returns at the edge of its transfer. Requests go
  // in bursts, with random gaps between the bursts.
  task automatic issue_request(input logic [ACTION_W-1:0] act,
                               input logic [SIZE_W-1:0] size,
                               input logic [BPOOL_W-1:0] bp,
                               input logic [BSLOT_W-1:0] bs);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 1);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(150, 60)
                                            : $urandom_range(20, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action   <= act;
    req_size <= size;
    buf_pool <= bp;
    buf_slot <= bs;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Stops offering and waits until every result is back, plus a short pause.
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all size class registers, one per cycle.
  task automatic write_classes(input logic [GRAN_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we      <= 1'b1;
      cfg_idx     <= REG_IDX_W'(i);
      cfg_data    <= vals[i];
      gran_cfg[i]  = vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Request size: mostly inside a configured class, some at class
  // boundaries, and some zero, maximal or fully random.
  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    int hi;
    r  = $urandom_range(99);
    hi = int'(gran_cfg[$urandom_range(NUM_REGS - 1)]) * GRANULE_BYTES_DEF;
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 22) return SIZE_W'($urandom);
    if (r < 34) return SIZE_W'(hi + $urandom_range(1));
    if (hi == 0) return SIZE_W'(1);
    return SIZE_W'($urandom_range(hi, 1));
  endfunction

  // Random traffic: mostly well-formed alloc and free pairs, with queries,
  // stray frees and the undefined action mixed in.
  task automatic run_random(input int alloc_pct, input int free_pct, input int count);
    int r;
    int k;
    logic [8:0] h;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < alloc_pct) begin
        issue_request(ACT_ALLOC, pick_size(), BPOOL_W'($urandom), BSLOT_W'($urandom));
      end else if (r < alloc_pct + free_pct) begin
        if (held_buffers.size() != 0 && $urandom_range(99) < 85) begin
          k = $urandom_range(held_buffers.size() - 1);
          h = held_buffers[k];
          held_buffers.delete(k);
          issue_request(ACT_FREE, SIZE_W'($urandom), {1'b0, h[8:6]}, h[5:0]);
        end else begin
          issue_request(ACT_FREE, SIZE_W'($urandom), BPOOL_W'($urandom),
                        BSLOT_W'($urandom));
        end
      end else if (r < 96) begin
        issue_request(ACT_QUERY, pick_size(), BPOOL_W'($urandom), BSLOT_W'($urandom));
      end else begin
        issue_request(ACT_RESERVED, SIZE_W'($urandom), BPOOL_W'($urandom),
                      BSLOT_W'($urandom));
      end
    end
  endtask

  // Main sequence: reset, directed requests, then phases of random traffic.
  initial begin : stimulus
    logic [GRAN_W-1:0] next_set [NUM_REGS];
    int acc;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset classes.
    issue_request(ACT_ALLOC, 16'd0, 4'd0, 6'd0);          // zero size
    issue_request(ACT_ALLOC, 16'd1, 4'd0, 6'd0);
    issue_request(ACT_ALLOC, 16'd64, 4'd0, 6'd0);
    issue_request(ACT_ALLOC, 16'd65, 4'd0, 6'd0);
    issue_request(ACT_ALLOC, 16'd8192, 4'd0, 6'd0);       // largest class
    issue_request(ACT_ALLOC, 16'd8193, 4'd15, 6'd63);     // just oversize
    issue_request(ACT_ALLOC, 16'hFFFF, 4'd15, 6'd63);
    issue_request(ACT_QUERY, 16'd100, 4'd0, 6'd0);
    issue_request(ACT_QUERY, 16'd0, 4'd0, 6'd0);
    issue_request(ACT_QUERY, 16'd8193, 4'd0, 6'd0);
    issue_request(ACT_QUERY, 16'd1, 4'd0, 6'd0);
    issue_request(ACT_FREE, 16'd0, 4'd0, 6'd1);           // valid free
    issue_request(ACT_FREE, 16'd0, 4'd0, 6'd1);           // freed twice
    issue_request(ACT_FREE, 16'd0, 4'd3, 6'd63);          // never allocated
    issue_request(ACT_FREE, 16'd0, 4'd8, 6'd0);           // pool out of range
    issue_request(ACT_FREE, 16'hFFFF, 4'd15, 6'd63);
    issue_request(ACT_RESERVED, 16'hFFFF, 4'd15, 6'd63);  // undefined action
    issue_request(ACT_ALLOC, 16'd128, 4'd0, 6'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        if (ph <= 5) begin
          next_set = CLASS_SETS[ph - 1];
        end else begin
          // Random ascending classes.
          acc = 0;
          for (int i = 0; i < NUM_REGS; i++) begin
            acc = acc + $urandom_range(70, 1);
            if (acc > 512) acc = 512;
            next_set[i] = GRAN_W'(acc);
          end
        end
        write_classes(next_set);
        if (ph == 1) hold_go = 1'b1;
      end
      if (ph % 2 == 0) run_random(60, 20, PHASE_ITEMS);
      else run_random(30, 50, PHASE_ITEMS);
    end

    // Drain and verdict.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
